@@ src/e2c_pkg.sv @@
// Shared types, constants and the month table for the epoch-to-calendar block.
// Depends on nothing; every other file in src imports it.
package e2c_pkg;

  // Depth of the queue between the time-of-day front and the calendar back.
  localparam int QUEUE_DEPTH = 2;

  // Seconds per day is 86400 = 128 * 675. The low seven bits pass straight
  // through and the rest is divided by 675 with an exact reciprocal.
  localparam int DAY_DIV = 675;
  localparam int DAY_SHIFT = 36;
  localparam logic [26:0] DAY_MUL =
      27'(((64'd1 << DAY_SHIFT) + 64'(DAY_DIV) - 64'd1) / 64'(DAY_DIV));

  // Division by sixty for values below 2^17.
  localparam int BASE60 = 60;
  localparam int MIN_SHIFT = 24;
  localparam logic [18:0] MIN_MUL =
      19'(((64'd1 << MIN_SHIFT) + 64'(BASE60) - 64'd1) / 64'(BASE60));

  // Year estimate: floor(days / 365) for day counts below 2^16.
  localparam int DAYS_COMMON_YEAR = 365;
  localparam int YEAR_SHIFT = 26;
  localparam logic [17:0] YEAR_MUL =
      18'(((64'd1 << YEAR_SHIFT) + 64'(DAYS_COMMON_YEAR) - 64'd1) /
          64'(DAYS_COMMON_YEAR));

  // Year indexes count from 1970.
  localparam int EPOCH_TO_1900 = 70;
  localparam int YEAR_2100_IDX = 130;
  localparam int YEAR_2101_IDX = 131;

  // One split timestamp as it waits in the queue.
  typedef struct packed {
    logic [15:0] days;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } tod_item_t;

  typedef struct packed {
    logic      valid;
    tod_item_t item;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // First day of year of each month.
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] mon);
    logic [8:0] base;
    case (mon)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (mon >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

@@ src/e2c_front.sv @@
// Front end: accepts a timestamp and splits it into whole days and
// hour, minute and second. Depends on e2c_pkg.
module e2c_front
  import e2c_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] epoch_seconds,
  input  q_status_t   status,
  output logic        busy,
  output push_t       push
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_DAY  = 3'd1;
  localparam logic [2:0] F_SOD  = 3'd2;
  localparam logic [2:0] F_MIN  = 3'd3;
  localparam logic [2:0] F_HOUR = 3'd4;
  localparam logic [2:0] F_PUSH = 3'd5;

  logic [2:0]  state;
  logic [31:0] t;
  logic [15:0] days;
  logic [16:0] sod;
  logic [10:0] mt;
  logic [5:0]  sec;
  logic [4:0]  ht;

  logic [51:0] day_prod;
  logic [24:0] day_rem;
  logic [35:0] min_prod;
  logic [35:0] hr_prod;
  logic [16:0] sec_full;
  logic [10:0] min_full;

  always_comb begin
    day_prod = 52'(t[31:7]) * 52'(DAY_MUL);
    day_rem  = t[31:7] - 25'(days) * 25'(DAY_DIV);
    min_prod = 36'(sod) * 36'(MIN_MUL);
    hr_prod  = 36'(mt) * 36'(MIN_MUL);
    sec_full = sod - 17'(mt) * 17'(BASE60);
    min_full = mt - 11'(ht) * 11'(BASE60);
  end

  assign busy = (state != F_IDLE);

  always_comb begin
    push.valid       = (state == F_PUSH) && !status.full;
    push.item.days   = days;
    push.item.hour   = ht;
    push.item.minute = min_full[5:0];
    push.item.second = sec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (start) begin
            state <= F_DAY;
          end
        end
        F_DAY:  state <= F_SOD;
        F_SOD:  state <= F_MIN;
        F_MIN:  state <= F_HOUR;
        F_HOUR: state <= F_PUSH;
        F_PUSH: begin
          if (!status.full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE) begin
      t <= epoch_seconds;
    end
    if (state == F_DAY) begin
      days <= day_prod[DAY_SHIFT +: 16];
    end
    if (state == F_SOD) begin
      sod <= {day_rem[9:0], t[6:0]};
    end
    if (state == F_MIN) begin
      mt <= min_prod[MIN_SHIFT +: 11];
    end
    if (state == F_HOUR) begin
      sec <= sec_full[5:0];
      ht  <= hr_prod[MIN_SHIFT +: 5];
    end
  end

endmodule

@@ src/e2c_queue.sv @@
// Short queue of split timestamps between the front and back ends.
// Depends on e2c_pkg for the entry type.
module e2c_queue
  import e2c_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  push_t     push,
  input  logic      pop,
  output tod_item_t head,
  output q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  tod_item_t        entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head         = entry[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry[wr_ptr] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push.valid && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push.valid) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !status.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

@@ src/e2c_back.sv @@
// Back end: finds year, day of year, month and day of month from the day
// count and drives the result beat. Depends on e2c_pkg.
module e2c_back
  import e2c_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  tod_item_t head,
  input  q_status_t status,
  output logic      pop,
  output logic      done,
  output logic [5:0] second,
  output logic [5:0] minute,
  output logic [4:0] hour,
  output logic [4:0] day_of_month,
  output logic [3:0] month,
  output logic [7:0] years_since_1900,
  output logic [8:0] day_of_year
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_EST  = 2'd1;
  localparam logic [1:0] B_FIX  = 2'd2;
  localparam logic [1:0] B_MON  = 2'd3;

  logic [1:0] state;
  tod_item_t  item;
  logic [7:0] ye;
  logic [8:0] yday;
  logic       leap;

  logic [33:0] year_prod;
  logic [8:0]  ye_p1;
  logic [16:0] ystart;
  logic        too_far;
  logic [3:0]  mon_c;
  logic [8:0]  dom_c;

  assign pop = (state == B_IDLE) && !status.empty;

  always_comb begin
    year_prod = 34'(item.days) * 34'(YEAR_MUL);
    ye_p1     = 9'(ye) + 9'd1;
    // Start day of year ye: common years plus leap days since 1970,
    // where 2100 is the only century year in range that is not leap.
    ystart    = 17'(ye) * 17'(DAYS_COMMON_YEAR) + 17'(ye_p1[8:2]) -
                17'(ye >= 8'(YEAR_2101_IDX));
    too_far   = ystart > {1'b0, item.days};
  end

  always_comb begin
    mon_c = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (yday >= month_start(leap, 4'(m))) begin
        mon_c = 4'(m);
      end
    end
    dom_c = yday - month_start(leap, mon_c) + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == B_MON);
      case (state)
        B_IDLE: begin
          if (!status.empty) begin
            state <= B_EST;
          end
        end
        B_EST: state <= B_FIX;
        B_FIX: begin
          if (!too_far) begin
            state <= B_MON;
          end
        end
        B_MON:   state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        item <= head;
      end
      B_EST: begin
        ye <= year_prod[YEAR_SHIFT +: 8];
      end
      B_FIX: begin
        if (too_far) begin
          ye <= ye - 8'd1;
        end else begin
          yday <= 9'(17'(item.days) - ystart);
          leap <= (ye[1:0] == 2'b10) && (ye != 8'(YEAR_2100_IDX));
        end
      end
      B_MON: begin
        second           <= item.second;
        minute           <= item.minute;
        hour             <= item.hour;
        day_of_month     <= dom_c[4:0];
        month            <= mon_c;
        years_since_1900 <= ye + 8'(EPOCH_TO_1900);
        day_of_year      <= yday;
      end
      default: begin
      end
    endcase
  end

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (month <= 4'd11) && (day_of_month >= 5'd1))
    else $error("month or day of month out of range");

  a_year_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (years_since_1900 >= 8'd70) && (years_since_1900 <= 8'd206) &&
             (day_of_year <= 9'd365))
    else $error("year or day of year out of range");

  a_est_floor: assert property (@(posedge clk) disable iff (rst)
    (state == B_FIX) && too_far |-> (ye != 8'd0))
    else $error("year correction stepped below 1970");

endmodule

@@ src/epoch_seconds_to_calendar.sv @@
// The front end takes one timestamp at a time: busy stays high from each accept
// through its day, seconds-of-day, minute, hour and push steps, and the push
// step waits while the queue is full.
// Reset (rst, synchronous) empties the queue and returns both ends to idle.
// The receiver cannot stall: each result is shown for exactly one cycle with done.
module epoch_seconds_to_calendar
  import e2c_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] epoch_seconds,
  output logic        done,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month,
  output logic [7:0]  years_since_1900,
  output logic [8:0]  day_of_year
);

  // The front end takes a beat when start is high and busy is low. It
  // divides by 86400 (as a pass-through of the low seven bits and an exact
  // reciprocal multiply by 1/675), then splits the seconds of the day by
  // sixty twice. Each reciprocal multiply has a register of its own.
  //
  // The finished split waits in a short queue, so the front can take the
  // next timestamp while the back end is still working on the last one.
  //
  // The back end estimates the year as days/365, which is never low and at
  // most one too high over the input range, and steps it down until the
  // start of that year is not past the day count. The month comes from a
  // compare against the table of month start days.

  push_t     push;
  tod_item_t head;
  q_status_t status;
  logic      pop;

  e2c_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .epoch_seconds (epoch_seconds),
    .status        (status),
    .busy          (busy),
    .push          (push)
  );

  e2c_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .status (status)
  );

  e2c_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .status           (status),
    .pop              (pop),
    .done             (done),
    .second           (second),
    .minute           (minute),
    .hour             (hour),
    .day_of_month     (day_of_month),
    .month            (month),
    .years_since_1900 (years_since_1900),
    .day_of_year      (day_of_year)
  );

endmodule
